[hdl/sfe_pkg.sv]
// ============================================================================
// sfe_pkg: shared types and constants of the stereo feedforward echo
// Holds the word formats of both channels, register selects and sizes.
// ============================================================================
`default_nettype none

package sfe_pkg;

    // Default number of frames held by each delay line.
    localparam int unsigned HISTORY_DEPTH_DEF = 32768;

    // Output queue size and the widths that follow from it.
    localparam int unsigned OFIFO_DEPTH = 4;
    localparam int unsigned OFIFO_AW    = 2;
    localparam int unsigned OFIFO_CW    = 3;

    // Register map: one 32-bit register every four bytes.
    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;

    localparam logic [15:0] GAIN_RESET = 16'd16384;

    typedef enum logic
    {
        REG_DELAY_LENGTH = 1'b0,
        REG_DECAY_GAIN   = 1'b1
    } reg_sel_t;

    typedef struct packed
    {
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
        logic               clip_start;
    } in_word_t;

    typedef struct packed
    {
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
    } out_word_t;

    // Per-word control that travels with a frame into both lanes.
    typedef struct packed
    {
        logic accept;
        logic bypass;
        logic pass;
    } lane_ctrl_t;

endpackage

`default_nettype wire

[hdl/stereo_feedforward_echo.sv]
// ============================================================================
// stereo_feedforward_echo: stereo feedforward comb-filter echo
// Adds a delayed, scaled copy of each channel's input to the live input.
// ============================================================================
// Usage. Each word on the sample channel is one stereo frame of signed 16-bit
// samples plus a clip_start flag that restarts the frame count of a clip.
// Each word on the result channel is the matching stereo output frame,
// x[n] + g*x[n-D], rounded to nearest (ties to even) and saturated. While
// fewer than D frames of the current clip have been seen, the input is
// passed through unchanged; every frame is still stored in the delay line.
// Both channels use valid/ready; a word moves when both are high.
// Throughput is one word per clock while the queue has room. A result
// reaches result_valid after the registered delay-line read and the
// registered gain multiply, after which the add, rounding and saturation
// feed a four-word output queue.
// sample_ready depends only on registers: it drops when the queue plus the
// words still in the pipeline would fill the queue, so a stalled receiver
// backs up the sender and no word is ever dropped.
// Reset clears the write pointer, the frame count, the queue and sets
// delay_length to 0 and decay_gain to 0.5 (16384). The delay-line memories
// are not cleared and need no clearing pass; only entries already written
// are ever used. Registers live on the APB port: delay_length at byte 0,
// decay_gain at byte 4. The user must write them only while the block is idle; the block does not enforce it.
// ============================================================================
`default_nettype none

module stereo_feedforward_echo
    import sfe_pkg::*;
#(
    parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,

    input  wire logic                sample_valid,
    output logic                     sample_ready,
    input  wire in_word_t            sample_word,

    output logic                     result_valid,
    input  wire logic                result_ready,
    output out_word_t                result_word,

    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready
);

    // Address width of the delay line, and a width wide enough to compare
    // delays, addresses and the 16-bit frame count without loss.
    localparam int unsigned AW = $clog2(HISTORY_DEPTH);
    localparam int unsigned DW = ((AW > 16) ? AW : 16) + 1;

    // Configuration registers.
    logic [14:0]     delay_reg;
    logic [15:0]     gain_reg;
    logic            cfg_write;

    // Stream state.
    logic [AW-1:0]   wp_reg;
    logic [AW-1:0]   wp_next;
    logic [15:0]     frames_reg;
    logic [15:0]     frames_next;
    logic [15:0]     frames_cur;

    // Valid bits of the two pipeline stages in front of the queue.
    logic            v1_reg;
    logic            v2_reg;

    logic            accept;
    logic [DW-1:0]   d_ext;
    logic [DW-1:0]   d_eff;
    logic [DW-1:0]   raddr_wide;
    logic [AW-1:0]   raddr;
    lane_ctrl_t      ctrl;
    logic signed [15:0] left_mixed;
    logic signed [15:0] right_mixed;
    logic [OFIFO_CW-1:0] q_count;
    logic [OFIFO_CW-1:0] occupancy;

    // ------------------------------------------------------------------
    // Register port. pready is tied high: every access completes in its
    // access phase.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= '0;
            gain_reg  <= GAIN_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_sel_t'(paddr[2]))
                REG_DELAY_LENGTH: delay_reg <= pwdata[14:0];
                REG_DECAY_GAIN:   gain_reg  <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel_t'(paddr[2]))
            REG_DELAY_LENGTH: prdata = PDATA_W'(delay_reg);
            REG_DECAY_GAIN:   prdata = PDATA_W'(gain_reg);
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input side. The queue has room for every word already in flight, so
    // the pipeline itself never stalls.
    // ------------------------------------------------------------------
    assign occupancy    = q_count + OFIFO_CW'(v1_reg) + OFIFO_CW'(v2_reg);
    assign sample_ready = (occupancy < OFIFO_CW'(OFIFO_DEPTH));
    assign accept       = sample_valid && sample_ready;

    // A delay at or beyond the line length is held to the longest one.
    always_comb
    begin
        d_ext = DW'(delay_reg);
        if (d_ext >= DW'(HISTORY_DEPTH))
        begin
            d_eff = DW'(HISTORY_DEPTH - 1);
        end
        else
        begin
            d_eff = d_ext;
        end
        if (DW'(wp_reg) >= d_eff)
        begin
            raddr_wide = DW'(wp_reg) - d_eff;
        end
        else
        begin
            raddr_wide = DW'(wp_reg) + DW'(HISTORY_DEPTH) - d_eff;
        end
        raddr = raddr_wide[AW-1:0];
    end

    // A clip start zeroes the count for the frame that carries it.
    assign frames_cur  = sample_word.clip_start ? 16'd0 : frames_reg;
    assign frames_next = (frames_cur != 16'hFFFF) ? frames_cur + 16'd1 : frames_cur;
    assign wp_next     = (wp_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + 1'b1;

    always_comb
    begin
        ctrl.accept = accept;
        ctrl.bypass = (d_eff == '0);
        ctrl.pass   = (DW'(frames_cur) < d_eff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg     <= '0;
            frames_reg <= '0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                wp_reg     <= wp_next;
                frames_reg <= frames_next;
            end
            v1_reg <= accept;
            v2_reg <= v1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Two identical lanes, one per audio channel.
    // ------------------------------------------------------------------
    sfe_lane #(
        .DEPTH (HISTORY_DEPTH)
    ) u_left (
        .clk    (clk),
        .ctrl   (ctrl),
        .waddr  (wp_reg),
        .raddr  (raddr),
        .sample (sample_word.left_sample),
        .gain   (gain_reg),
        .mixed  (left_mixed)
    );

    sfe_lane #(
        .DEPTH (HISTORY_DEPTH)
    ) u_right (
        .clk    (clk),
        .ctrl   (ctrl),
        .waddr  (wp_reg),
        .raddr  (raddr),
        .sample (sample_word.right_sample),
        .gain   (gain_reg),
        .mixed  (right_mixed)
    );

    // ------------------------------------------------------------------
    // The lane results are merged into one output word and queued.
    // ------------------------------------------------------------------
    sfe_ofifo u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (v2_reg),
        .left_mixed  (left_mixed),
        .right_mixed (right_mixed),
        .pop         (result_ready),
        .word        (result_word),
        .valid       (result_valid),
        .count       (q_count)
    );

endmodule

`default_nettype wire

[hdl/sfe_lane.sv]
// ============================================================================
// sfe_lane: one audio channel of the echo
// Delay-line memory, gain multiply, round-to-even and saturation.
// ============================================================================
`default_nettype none

module sfe_lane
    import sfe_pkg::*;
#(
    parameter int unsigned DEPTH = HISTORY_DEPTH_DEF,
    localparam int unsigned AW   = $clog2(DEPTH)
)
(
    input  wire logic               clk,
    input  wire lane_ctrl_t         ctrl,
    input  wire logic [AW-1:0]      waddr,
    input  wire logic [AW-1:0]      raddr,
    input  wire logic signed [15:0] sample,
    input  wire logic [15:0]        gain,
    output logic signed [15:0]      mixed
);

    logic signed [15:0] mem [DEPTH];

    logic signed [15:0] rd_reg;
    logic signed [15:0] cur1_reg;
    logic               byp1_reg;
    logic               pass1_reg;

    logic signed [32:0] prod2_reg;
    logic signed [15:0] cur2_reg;
    logic               pass2_reg;

    logic signed [15:0] past;
    logic signed [33:0] sum;
    logic signed [18:0] fl;
    logic [14:0]        rem;
    logic               inc;
    logic signed [19:0] rounded;
    logic signed [15:0] sat;

    // Write the new frame and read the delayed one in the same cycle.
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            mem[waddr] <= sample;
            rd_reg     <= mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            cur1_reg  <= sample;
            byp1_reg  <= ctrl.bypass;
            pass1_reg <= ctrl.pass;
        end
        prod2_reg <= past * $signed({1'b0, gain});
        cur2_reg  <= cur1_reg;
        pass2_reg <= pass1_reg;
    end

    // With zero delay the read collides with the write, so the delayed
    // sample is the current one.
    assign past = byp1_reg ? cur1_reg : rd_reg;

    always_comb
    begin
        sum     = (34'(cur2_reg) <<< 15) + 34'(prod2_reg);
        fl      = sum[33:15];
        rem     = sum[14:0];
        inc     = (rem > 15'h4000) || ((rem == 15'h4000) && fl[0]);
        rounded = 20'(fl) + 20'(inc);
        if (rounded > 20'sd32767)
        begin
            sat = 16'sh7FFF;
        end
        else if (rounded < -20'sd32768)
        begin
            sat = -16'sh8000;
        end
        else
        begin
            sat = rounded[15:0];
        end
        mixed = pass2_reg ? cur2_reg : sat;
    end

endmodule

`default_nettype wire

[hdl/sfe_ofifo.sv]
// ============================================================================
// sfe_ofifo: result queue of the echo
// Merges both lane results into one word and buffers it for the receiver.
// ============================================================================
`default_nettype none

module sfe_ofifo
    import sfe_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire logic signed [15:0]  left_mixed,
    input  wire logic signed [15:0]  right_mixed,
    input  wire logic                pop,
    output out_word_t                word,
    output logic                     valid,
    output logic [OFIFO_CW-1:0]      count
);

    out_word_t             store [OFIFO_DEPTH];
    logic [OFIFO_AW-1:0]   wptr_reg;
    logic [OFIFO_AW-1:0]   wptr_next;
    logic [OFIFO_AW-1:0]   rptr_reg;
    logic [OFIFO_AW-1:0]   rptr_next;
    logic [OFIFO_CW-1:0]   count_reg;
    logic [OFIFO_CW-1:0]   count_next;
    logic                  do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_comb
    begin
        wptr_next  = push   ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = do_pop ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg + OFIFO_CW'(push) - OFIFO_CW'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wptr_reg] <= '{left_out: left_mixed, right_out: right_mixed};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    assign word  = store[rptr_reg];
    assign valid = (count_reg != '0);
    assign count = count_reg;

endmodule

`default_nettype wire

[hdl/sfe_checker.sv]
// ============================================================================
// sfe_checker: port-level checks of the stereo feedforward echo
// Watches latency, flow control and register read-back at the top level.
// ============================================================================
`default_nettype none

module sfe_checker
    import sfe_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                sample_valid,
    input  wire logic                sample_ready,
    input  wire logic                result_valid,
    input  wire logic                result_ready,
    input  wire out_word_t           result_word,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [PDATA_W-1:0]  pwdata,
    input  wire logic [PDATA_W-1:0]  prdata,
    input  wire logic                pready
);

    // A stalled result word stays on the port unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_word))
    else $error("result word changed while stalled");

    // Every accepted word has a result waiting once it has passed the pipeline.
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |-> ##3 result_valid)
    else $error("accepted word did not produce a result in time");

    // The sender is only held off while results are backed up.
    assert property (@(posedge clk) disable iff (!rst_n)
        !sample_ready |-> result_valid)
    else $error("input stalled with no result pending");

    // A delay written and read back in the next cycle reads as written.
    assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && !paddr[2])
        ##1 (psel && !pwrite && !paddr[2])
        |-> prdata == {17'd0, $past(pwdata[14:0])})
    else $error("delay register read-back mismatch");

endmodule

bind stereo_feedforward_echo sfe_checker u_sfe_checker (.*);

`default_nettype wire

[tb/sv/stereo_feedforward_echo_tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// stereo_feedforward_echo_tb: self-checking bench for the stereo echo
// Feeds stereo frames through the sample channel, predicts every output word
// from an in-bench model of the delay lines, and compares field by field.
// ============================================================================
module stereo_feedforward_echo_tb;

    import sfe_pkg::*;

    localparam int unsigned LINE_DEPTH  = HISTORY_DEPTH_DEF;
    localparam int unsigned IDLE_LIMIT  = 2000;
    localparam int unsigned FRAME_GOAL  = 1460;
    localparam int unsigned PRINT_LIMIT = 40;

    // One row of the directed part. Where 'known' is set, the expected output
    // is typed in; otherwise the predictor supplies it.
    typedef struct {
        in_word_t  stim;
        bit        known;
        out_word_t want;
    } probe_row_t;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                sample_valid = 1'b0;
    logic                sample_ready;
    in_word_t            sample_word  = '0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    out_word_t           result_word;
    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [PADDR_W-1:0]  paddr        = '0;
    logic [PDATA_W-1:0]  pwdata       = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // Bench-side copy of the block's state and its two registers.
    logic signed [15:0]  left_line  [LINE_DEPTH];
    logic signed [15:0]  right_line [LINE_DEPTH];
    int unsigned         line_wr_ptr  = 0;
    int unsigned         clip_frames  = 0;
    int unsigned         echo_delay   = 0;
    int unsigned         echo_gain    = 16384;

    // Output words still owed by the block, oldest first.
    out_word_t           pending_frames [$];

    int unsigned         frames_sent     = 0;
    int unsigned         mismatch_count  = 0;
    int unsigned         idle_cycles     = 0;
    int unsigned         ready_hold      = 0;
    bit                  quiet_phase     = 1'b0;

    // Directed frames, run at the reset settings: no delay and a gain of one
    // half, so every output is 1.5 times its input. That makes the rounding
    // ties (odd inputs) and both saturation limits easy to write down.
    probe_row_t probe_rows [12] = '{
        '{'{16'sd0,      16'sd0,      1'b1}, 1'b1, '{16'sd0,      16'sd0     }},
        '{'{16'h7FFF,    16'h8000,    1'b0}, 1'b1, '{16'h7FFF,    16'h8000   }},
        '{'{16'h8000,    16'h7FFF,    1'b0}, 1'b1, '{16'h8000,    16'h7FFF   }},
        '{'{16'sd1,      -16'sd1,     1'b0}, 1'b1, '{16'sd2,      -16'sd2    }},
        '{'{16'sd3,      -16'sd3,     1'b0}, 1'b1, '{16'sd4,      -16'sd4    }},
        '{'{16'sd2,      16'sd5,      1'b0}, 1'b1, '{16'sd3,      16'sd8     }},
        '{'{16'h5555,    16'hAAAA,    1'b1}, 1'b1, '{16'h7FFF,    16'h8000   }},
        '{'{16'sd21844,  -16'sd21845, 1'b0}, 1'b1, '{16'sd32766,  16'h8000   }},
        '{'{-16'sd2,     16'sd7,      1'b0}, 1'b1, '{-16'sd3,     16'sd10    }},
        '{'{16'sd12345,  -16'sd4321,  1'b1}, 1'b0, '{16'sd0,      16'sd0     }},
        '{'{-16'sd30000, 16'sd9999,   1'b0}, 1'b0, '{16'sd0,      16'sd0     }},
        '{'{16'sd255,    -16'sd256,   1'b1}, 1'b0, '{16'sd0,      16'sd0     }}
    };

    stereo_feedforward_echo dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_word  (sample_word),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_word  (result_word),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Mixes the live sample with the delayed one: the sum is formed exactly
    // at Q15 scale, brought back to sample scale with round-half-to-even,
    // and clamped to the 16-bit range.
    function automatic logic signed [15:0] echo_mix(
        input logic signed [15:0] live,
        input logic signed [15:0] past,
        input int unsigned        gain
    );
        longint acc;
        longint quo;
        acc = longint'(live) * 32768 + longint'(past) * longint'(gain);
        quo = acc >>> 15;
        if (acc[14:0] > 15'h4000 || (acc[14:0] == 15'h4000 && quo[0]))
        begin
            quo = quo + 1;
        end
        if (quo > 32767)
        begin
            quo = 32767;
        end
        if (quo < -32768)
        begin
            quo = -32768;
        end
        return quo[15:0];
    endfunction

    // Advances the bench copy of the delay lines by one frame and returns
    // the output word the block must produce for it. A 15-bit delay always
    // stays below the line depth, so no clamping of the delay is needed.
    task automatic echo_predict(input in_word_t frame, output out_word_t y);
        int unsigned rd_ptr;
        if (frame.clip_start)
        begin
            clip_frames = 0;
        end
        left_line[line_wr_ptr]  = frame.left_sample;
        right_line[line_wr_ptr] = frame.right_sample;
        rd_ptr = (line_wr_ptr + LINE_DEPTH - echo_delay) % LINE_DEPTH;
        if (clip_frames < echo_delay)
        begin
            // Not enough history in this clip yet: the frame passes through.
            y.left_out  = frame.left_sample;
            y.right_out = frame.right_sample;
        end
        else
        begin
            y.left_out  = echo_mix(frame.left_sample, left_line[rd_ptr], echo_gain);
            y.right_out = echo_mix(frame.right_sample, right_line[rd_ptr], echo_gain);
        end
        line_wr_ptr = (line_wr_ptr + 1) % LINE_DEPTH;
        if (clip_frames < 65535)
        begin
            clip_frames = clip_frames + 1;
        end
    endtask

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT)
        begin
            $display("%0t ns: mismatch: %s", $time, msg);
        end
        mismatch_count = mismatch_count + 1;
    endtask

    // Idle stretch length: mostly none or short, now and then long. Quiet
    // phases run without any idling at all.
    function automatic int unsigned idle_len();
        int unsigned pick;
        if (quiet_phase)
        begin
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 50)
        begin
            return 0;
        end
        if (pick < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (pick < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Samples lean toward the two rails and tiny values, the rest spread
    // over the whole 16-bit range.
    function automatic logic signed [15:0] pick_sample();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            return 16'h7FFF;
        end
        if (pick == 1)
        begin
            return 16'h8000;
        end
        if (pick == 2)
        begin
            return 16'($urandom_range(0, 15)) - 16'sd8;
        end
        return 16'($urandom());
    endfunction

    function automatic int unsigned pick_gain();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 16384;
            2:       return 32768;
            3:       return 32769;
            4:       return 65535;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    function automatic int unsigned pick_delay();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            return 0;
        end
        if (pick < 70)
        begin
            return $urandom_range(1, 32);
        end
        if (pick < 90)
        begin
            return $urandom_range(33, 300);
        end
        return $urandom_range(301, 2000);
    endfunction

    // Presents one word on the sample channel and holds it until the block
    // takes it. Valid is only dropped when an idle stretch comes first, so
    // back-to-back words keep it high across the edge.
    task automatic send_frame(input in_word_t frame, input bit known,
                              input out_word_t typed);
        int unsigned gap;
        out_word_t   y;
        gap = idle_len();
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_word  <= frame;
        do
        begin
            @(posedge clk);
        end
        while (!sample_ready);
        echo_predict(frame, y);
        pending_frames.push_back(known ? typed : y);
        frames_sent = frames_sent + 1;
    endtask

    // Stops sending and waits until every owed word has come back, then waits
    // for the two pipeline stages and the output queue to settle.
    task automatic drain();
        sample_valid <= 1'b0;
        while (pending_frames.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Setup cycle, then an access cycle that completes once pready is seen.
    task automatic reg_write(input reg_sel_t sel, input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == REG_DELAY_LENGTH)
        begin
            echo_delay = value & 32'h7FFF;
        end
        else
        begin
            echo_gain = value & 32'hFFFF;
        end
    endtask

    // One setting of the registers followed by a run of frames. With clips
    // on, clip starts come at intervals a bit longer than the delay so each
    // clip reaches its echo region; a stray clip start now and then breaks
    // a clip early. With clips off the frame count keeps growing, which is
    // what lets a long delay reach back into the line. Half of the clipped
    // phases begin mid-clip, so the new delay reads older history.
    task automatic run_phase(input int unsigned delay, input int unsigned gain,
                             input int unsigned frames, input bit clips,
                             input bit quiet);
        int unsigned clip_left;
        bit          start;
        in_word_t    frame;
        drain();
        reg_write(REG_DELAY_LENGTH, delay);
        reg_write(REG_DECAY_GAIN, gain);
        quiet_phase = quiet;
        clip_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 20);
        repeat (frames)
        begin
            start = 1'b0;
            if (clips)
            begin
                if (clip_left == 0 || $urandom_range(0, 39) == 0)
                begin
                    start     = 1'b1;
                    clip_left = $urandom_range(delay, delay + 40);
                end
                else
                begin
                    clip_left = clip_left - 1;
                end
            end
            frame.left_sample  = pick_sample();
            frame.right_sample = pick_sample();
            frame.clip_start   = start;
            send_frame(frame, 1'b0, '0);
        end
    endtask

    // Result side: checks each accepted word against the oldest expectation,
    // stalls at random, and tracks how long nothing has moved on either side.
    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_frames.size() == 0)
            begin
                report_mismatch($sformatf("result word L=%0d R=%0d with none owed",
                                          result_word.left_out, result_word.right_out));
            end
            else
            begin
                want = pending_frames.pop_front();
                if (result_word.left_out !== want.left_out)
                begin
                    report_mismatch($sformatf("left_out %0d, wanted %0d",
                                              result_word.left_out, want.left_out));
                end
                if (result_word.right_out !== want.right_out)
                begin
                    report_mismatch($sformatf("right_out %0d, wanted %0d",
                                              result_word.right_out, want.right_out));
                end
            end
        end

        if ((sample_valid && sample_ready) || (result_valid && result_ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles = idle_cycles + 1;
        end

        if (ready_hold == 0)
        begin
            ready_hold = idle_len();
            if (ready_hold == 0)
            begin
                result_ready <= 1'b1;
                ready_hold = $urandom_range(1, 12) - 1;
            end
            else
            begin
                result_ready <= 1'b0;
                ready_hold = ready_hold - 1;
            end
        end
        else
        begin
            ready_hold = ready_hold - 1;
        end
    end

    // Nothing accepted on either channel for this long means the block hung.
    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at the reset register values.
        foreach (probe_rows[i])
        begin
            send_frame(probe_rows[i].stim, probe_rows[i].known, probe_rows[i].want);
        end

        // Register extremes first: one-frame delay at unity gain, gains just
        // above one and at the top of the field, zero gain, the longest delay
        // (passthrough only, it never fills here), and a delay raised in the
        // middle of a long clip so it reads far back into the line.
        run_phase(1,     32768, 40,  1'b1, 1'b0);
        run_phase(3,     65535, 40,  1'b1, 1'b0);
        run_phase(2,     32769, 30,  1'b1, 1'b1);
        run_phase(0,     0,     20,  1'b1, 1'b0);
        run_phase(32767, 12345, 20,  1'b0, 1'b0);
        run_phase(40,    30000, 150, 1'b0, 1'b0);
        run_phase(170,   20000, 60,  1'b0, 1'b0);
        run_phase(0,     65535, 20,  1'b0, 1'b0);

        while (frames_sent < FRAME_GOAL)
        begin
            run_phase(pick_delay(), pick_gain(), $urandom_range(20, 100),
                      $urandom_range(0, 3) != 0, $urandom_range(0, 4) == 0);
        end

        drain();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
